// ===== design/json_top_level_key_scanner_unit_macros.svh =====
// Assertion macros used by the scanner's top-level RTL file.
`ifndef JSON_TOP_LEVEL_KEY_SCANNER_UNIT_MACROS_SVH
`define JSON_TOP_LEVEL_KEY_SCANNER_UNIT_MACROS_SVH

// A property checked on every rising edge while reset is released.
`define JTKS_ASSERT_ALWAYS(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// A condition that must hold in the cycle after a trigger.
`define JTKS_ASSERT_NEXT(label, clk, rst_n, trig, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (trig) |=> (prop)) \
        else $error(msg);

`endif

// ===== design/jtks_pkg.sv =====
`default_nettype none

package jtks_pkg;

    localparam int unsigned KEY_W = 32;

    localparam logic [7:0] CH_LBRACK    = 8'h5B;
    localparam logic [7:0] CH_RBRACK    = 8'h5D;
    localparam logic [7:0] CH_LBRACE    = 8'h7B;
    localparam logic [7:0] CH_RBRACE    = 8'h7D;
    localparam logic [7:0] CH_COLON     = 8'h3A;
    localparam logic [7:0] CH_COMMA     = 8'h2C;
    localparam logic [7:0] CH_QUOTE     = 8'h22;
    localparam logic [7:0] CH_BACKSLASH = 8'h5C;
    localparam logic [7:0] CH_SPACE     = 8'h20;
    localparam logic [7:0] CH_TAB       = 8'h09;
    localparam logic [7:0] CH_CR        = 8'h0D;
    localparam logic [7:0] CH_LF        = 8'h0A;

    localparam logic EVT_KEY   = 1'b0;
    localparam logic EVT_VALUE = 1'b1;

    typedef enum logic [3:0] {
        MODE_WAIT   = 4'b0001,
        MODE_ARRAY  = 4'b0010,
        MODE_OBJECT = 4'b0100,
        MODE_SCALAR = 4'b1000
    } t_doc_mode;

    typedef struct packed {
        logic             valid;
        logic             kind;
        logic [KEY_W-1:0] key_start;
        logic [KEY_W-1:0] key_end;
    } t_event;

    typedef struct packed {
        t_doc_mode mode;
        logic      in_string;
        logic      key_pending;
        logic      pos_zero;
    } t_scan_status;

endpackage

`default_nettype wire

// ===== design/jtks_if.sv =====
`default_nettype none

interface jtks_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] doc_byte;
    logic       last;

    modport source (output valid, output doc_byte, output last, input ready);
    modport sink   (input valid, input doc_byte, input last, output ready);
endinterface

interface jtks_event_if;
    logic                        valid;
    logic                        ready;
    logic                        event_kind;
    logic [jtks_pkg::KEY_W-1:0]  key_start;
    logic [jtks_pkg::KEY_W-1:0]  key_end;

    modport source (output valid, output event_kind, output key_start, output key_end,
                    input ready);
    modport sink   (input valid, input event_kind, input key_start, input key_end,
                    output ready);
endinterface

`default_nettype wire

// ===== design/jtks_scan_core.sv =====
`default_nettype none

module jtks_scan_core #(
    parameter int unsigned DEPTH_BITS  = 16,
    parameter int unsigned OFFSET_BITS = 32
) (
    input  wire logic                   i_clk,
    input  wire logic                   i_rst_n,
    input  wire logic                   i_en,
    input  wire logic [7:0]             i_doc_byte,
    input  wire logic                   i_last,
    output jtks_pkg::t_event            o_evt,
    output jtks_pkg::t_scan_status      o_status
);

    localparam logic [DEPTH_BITS-1:0] DEPTH_MAX = {DEPTH_BITS{1'b1}};

    jtks_pkg::t_doc_mode      r_mode, n_mode;
    logic                     r_elem_obj, n_elem_obj;
    logic [DEPTH_BITS-1:0]    r_depth, n_depth;
    logic                     r_in_string, n_in_string;
    logic                     r_escape, n_escape;
    logic                     r_at_row, n_at_row;
    logic                     r_key_pending, n_key_pending;
    logic                     r_skip, n_skip;
    logic [OFFSET_BITS-1:0]   r_pend_start, n_pend_start;
    logic [OFFSET_BITS-1:0]   r_pend_end, n_pend_end;
    logic [OFFSET_BITS-1:0]   r_pos, n_pos;

    logic                     is_space;
    jtks_pkg::t_event         evt;

    assign is_space = i_doc_byte inside {jtks_pkg::CH_SPACE, jtks_pkg::CH_TAB,
                                         jtks_pkg::CH_CR, jtks_pkg::CH_LF};

    always_comb begin
        logic                  go;
        logic                  arr;
        logic                  at_top;
        logic                  at_row;
        logic [DEPTH_BITS-1:0] key_depth;

        n_mode        = r_mode;
        n_elem_obj    = r_elem_obj;
        n_depth       = r_depth;
        n_in_string   = r_in_string;
        n_escape      = r_escape;
        n_at_row      = r_at_row;
        n_key_pending = r_key_pending;
        n_skip        = r_skip;
        n_pend_start  = r_pend_start;
        n_pend_end    = r_pend_end;
        n_pos         = r_pos + OFFSET_BITS'(1);
        evt           = '{valid: 1'b0, kind: jtks_pkg::EVT_KEY, key_start: '0, key_end: '0};
        go            = 1'b1;

        // The first non-space byte fixes the document mode.
        if (r_mode == jtks_pkg::MODE_WAIT && !is_space) begin
            if (i_doc_byte == jtks_pkg::CH_LBRACK) begin
                n_mode = jtks_pkg::MODE_ARRAY;
            end else if (i_doc_byte == jtks_pkg::CH_LBRACE) begin
                n_mode     = jtks_pkg::MODE_OBJECT;
                n_elem_obj = 1'b1;
            end else begin
                n_mode    = jtks_pkg::MODE_SCALAR;
                evt.valid = 1'b1;
                evt.kind  = jtks_pkg::EVT_VALUE;
            end
        end

        arr       = (n_mode == jtks_pkg::MODE_ARRAY);
        at_top    = arr && (r_depth == DEPTH_BITS'(1));
        key_depth = arr ? DEPTH_BITS'(2) : DEPTH_BITS'(1);
        at_row    = n_elem_obj && (r_depth == key_depth);

        if (n_mode == jtks_pkg::MODE_ARRAY || n_mode == jtks_pkg::MODE_OBJECT) begin
            if (r_in_string) begin
                if (r_escape) begin
                    n_escape = 1'b0;
                end else if (i_doc_byte == jtks_pkg::CH_BACKSLASH) begin
                    n_escape = 1'b1;
                end else if (i_doc_byte == jtks_pkg::CH_QUOTE) begin
                    n_in_string = 1'b0;
                    if (r_at_row) begin
                        n_key_pending = 1'b1;
                        n_pend_end    = r_pos;
                    end
                end
            end else begin
                if (r_key_pending) begin
                    if (is_space) begin
                        go = 1'b0;
                    end else begin
                        n_key_pending = 1'b0;
                        if (i_doc_byte == jtks_pkg::CH_COLON) begin
                            go            = 1'b0;
                            evt.valid     = 1'b1;
                            evt.kind      = jtks_pkg::EVT_KEY;
                            evt.key_start = jtks_pkg::KEY_W'(r_pend_start);
                            evt.key_end   = jtks_pkg::KEY_W'(r_pend_end);
                        end
                    end
                end
                if (go && r_skip) begin
                    if (i_doc_byte != jtks_pkg::CH_COMMA && i_doc_byte != jtks_pkg::CH_RBRACK) begin
                        go = 1'b0;
                    end else begin
                        n_skip = 1'b0;
                    end
                end
                if (go) begin
                    if (i_doc_byte == jtks_pkg::CH_QUOTE) begin
                        n_in_string = 1'b1;
                        n_escape    = 1'b0;
                        n_at_row    = at_row;
                        if (at_row) begin
                            n_pend_start = r_pos;
                        end else if (at_top) begin
                            evt.valid = 1'b1;
                            evt.kind  = jtks_pkg::EVT_VALUE;
                        end
                    end else if (i_doc_byte == jtks_pkg::CH_LBRACE ||
                                 i_doc_byte == jtks_pkg::CH_LBRACK) begin
                        if (at_top) begin
                            n_elem_obj = (i_doc_byte == jtks_pkg::CH_LBRACE);
                            if (i_doc_byte == jtks_pkg::CH_LBRACK) begin
                                evt.valid = 1'b1;
                                evt.kind  = jtks_pkg::EVT_VALUE;
                            end
                        end
                        if (r_depth != DEPTH_MAX) begin
                            n_depth = r_depth + DEPTH_BITS'(1);
                        end
                    end else if (i_doc_byte == jtks_pkg::CH_RBRACE ||
                                 i_doc_byte == jtks_pkg::CH_RBRACK) begin
                        if (r_depth != '0) begin
                            n_depth = r_depth - DEPTH_BITS'(1);
                        end
                    end else if (at_top && i_doc_byte != jtks_pkg::CH_COMMA && !is_space) begin
                        n_skip    = 1'b1;
                        evt.valid = 1'b1;
                        evt.kind  = jtks_pkg::EVT_VALUE;
                    end
                end
            end
        end

        // The final byte closes the document and returns the scanner to its start.
        if (i_last) begin
            if (n_mode == jtks_pkg::MODE_WAIT) begin
                evt.valid = 1'b1;
                evt.kind  = jtks_pkg::EVT_VALUE;
            end
            n_mode        = jtks_pkg::MODE_WAIT;
            n_elem_obj    = 1'b0;
            n_depth       = '0;
            n_in_string   = 1'b0;
            n_escape      = 1'b0;
            n_at_row      = 1'b0;
            n_key_pending = 1'b0;
            n_skip        = 1'b0;
            n_pos         = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode        <= jtks_pkg::MODE_WAIT;
            r_elem_obj    <= 1'b0;
            r_depth       <= '0;
            r_in_string   <= 1'b0;
            r_escape      <= 1'b0;
            r_at_row      <= 1'b0;
            r_key_pending <= 1'b0;
            r_skip        <= 1'b0;
            r_pos         <= '0;
        end else if (i_en) begin
            r_mode        <= n_mode;
            r_elem_obj    <= n_elem_obj;
            r_depth       <= n_depth;
            r_in_string   <= n_in_string;
            r_escape      <= n_escape;
            r_at_row      <= n_at_row;
            r_key_pending <= n_key_pending;
            r_skip        <= n_skip;
            r_pos         <= n_pos;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_pend_start <= n_pend_start;
            r_pend_end   <= n_pend_end;
        end
    end

    assign o_evt                = evt;
    assign o_status.mode        = r_mode;
    assign o_status.in_string   = r_in_string;
    assign o_status.key_pending = r_key_pending;
    assign o_status.pos_zero    = (r_pos == '0);

endmodule

`default_nettype wire

// ===== design/json_top_level_key_scanner_unit.sv =====
// Structural key scanner for a validated JSON document.
// The i_byte channel carries the document one byte per transfer, with last set on
// the final byte. The o_event channel carries at most one event per byte: a key
// event with the offsets of a row key's opening and closing quotes, or a value
// event (offsets zero) for a non-object array element, a scalar document or an
// empty document. Each accepted byte is held in an input register, scanned from
// there once the output register is free, and its event, if any, lands in the
// output register. One byte is taken per cycle while the receiver takes events,
// set by the single pass of the scanning logic between the two registers.
// While the output register holds an event that the receiver does not take, the
// byte waiting in the input register stays there and i_byte.ready drops once that
// register is full; no event is lost or repeated.
// After the byte marked last the scanner state returns to its reset values and the
// next byte starts a new document at offset zero. Reset (i_rst_n low, synchronous)
// empties both registers and clears the scanner state.
`default_nettype none
`include "json_top_level_key_scanner_unit_macros.svh"

module json_top_level_key_scanner_unit #(
    parameter int unsigned DEPTH_BITS  = 16,
    parameter int unsigned OFFSET_BITS = 32
) (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    jtks_byte_if.sink       i_byte,
    jtks_event_if.source    o_event
);

    logic                      r_in_valid;
    logic [7:0]                r_in_byte;
    logic                      r_in_last;
    logic                      r_out_valid;
    jtks_pkg::t_event          r_out;
    logic                      proc;
    jtks_pkg::t_event          evt;
    jtks_pkg::t_scan_status    status;

    assign proc         = r_in_valid && (!r_out_valid || o_event.ready);
    assign i_byte.ready = !r_in_valid || proc;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (i_byte.valid && i_byte.ready) begin
            r_in_valid <= 1'b1;
        end else if (proc) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_byte.valid && i_byte.ready) begin
            r_in_byte <= i_byte.doc_byte;
            r_in_last <= i_byte.last;
        end
    end

    jtks_scan_core #(
        .DEPTH_BITS  (DEPTH_BITS),
        .OFFSET_BITS (OFFSET_BITS)
    ) u_core (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_en       (proc),
        .i_doc_byte (r_in_byte),
        .i_last     (r_in_last),
        .o_evt      (evt),
        .o_status   (status)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (proc && evt.valid) begin
            r_out_valid <= 1'b1;
        end else if (o_event.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (proc && evt.valid) begin
            r_out <= evt;
        end
    end

    assign o_event.valid      = r_out_valid;
    assign o_event.event_kind = r_out.kind;
    assign o_event.key_start  = r_out.key_start;
    assign o_event.key_end    = r_out.key_end;

    `JTKS_ASSERT_ALWAYS(a_stall_holds_input, i_clk, i_rst_n, !(r_in_valid && r_out_valid && !o_event.ready && i_byte.ready), "input taken while the scanner is stalled")
    `JTKS_ASSERT_ALWAYS(a_string_needs_struct, i_clk, i_rst_n, !(status.in_string || status.key_pending) || status.mode == jtks_pkg::MODE_ARRAY || status.mode == jtks_pkg::MODE_OBJECT, "string state outside array or object mode")
    `JTKS_ASSERT_NEXT(a_last_restarts, i_clk, i_rst_n, proc && r_in_last, status.mode == jtks_pkg::MODE_WAIT && status.pos_zero, "scanner not restarted after the final byte")

endmodule

`default_nettype wire
